// ----- src/json_string_unescape_macros.svh -----
// assertion helpers shared by jsu_fifo and jsu_back
`ifndef JSON_STRING_UNESCAPE_MACROS_SVH
`define JSON_STRING_UNESCAPE_MACROS_SVH

// same-cycle implication, checked outside reset
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and constants shared by the JSON string unescaper modules.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 2;
  localparam int HEX_W      = 4;
  localparam int HEXACC_W   = 12;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [BYTE_W-1:0] QUOTE_RESET = 8'h22;

  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5c;
  localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2f;
  localparam logic [BYTE_W-1:0] CH_B      = 8'h62;
  localparam logic [BYTE_W-1:0] CH_F      = 8'h66;
  localparam logic [BYTE_W-1:0] CH_N      = 8'h6e;
  localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
  localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
  localparam logic [BYTE_W-1:0] CH_U      = 8'h75;
  localparam logic [BYTE_W-1:0] CH_0      = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9      = 8'h39;
  localparam logic [BYTE_W-1:0] CH_UA     = 8'h41;
  localparam logic [BYTE_W-1:0] CH_UF     = 8'h46;
  localparam logic [BYTE_W-1:0] CH_LA     = 8'h61;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h66;

  localparam logic [BYTE_W-1:0] CTL_BS = 8'h08;
  localparam logic [BYTE_W-1:0] CTL_FF = 8'h0c;
  localparam logic [BYTE_W-1:0] CTL_LF = 8'h0a;
  localparam logic [BYTE_W-1:0] CTL_CR = 8'h0d;
  localparam logic [BYTE_W-1:0] CTL_HT = 8'h09;

  localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BAD_HEX = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TOO_BIG = 2'd3;

  localparam logic [1:0] HEX_LAST = 2'd3;

  // classified input byte
  typedef struct packed {
    logic [BYTE_W-1:0] raw;
    logic              is_bslash;
    logic              is_quote;
    logic              esc_known;
    logic [BYTE_W-1:0] esc_byte;
    logic              is_u;
    logic              hex_ok;
    logic [HEX_W-1:0]  hex_val;
  } tok_t;

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_ESC,
    MODE_HEX
  } mode_t;

endpackage

// ----- src/jsu_fifo.sv -----
// ----------------------------------------------------------------------------
// jsu_fifo
// Short token queue between the classifier and the decoder.
// ----------------------------------------------------------------------------
module jsu_fifo (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  jsu_pkg::tok_t wr_tok,
  output logic         full,
  input  logic         pop,
  output jsu_pkg::tok_t rd_tok,
  output logic         empty
);
  import jsu_pkg::*;
  `include "json_string_unescape_macros.svh"

  tok_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;

  assign full   = (count == FIFO_CW'(FIFO_DEPTH));
  assign empty  = (count == '0);
  assign rd_tok = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `JSU_ASSERT_NOW(a_no_overflow, push, !full || pop, "push into full queue")
  `JSU_ASSERT_NOW(a_no_underflow, pop, !empty, "pop from empty queue")
  `JSU_ASSERT_NEXT(a_push_fills, push && !pop, !empty, "queue empty after push")

endmodule

// ----- src/jsu_front.sv -----
// ----------------------------------------------------------------------------
// jsu_front
// Input side: holds the terminator register and classifies each byte.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [jsu_pkg::BYTE_W-1:0] cfg_wr_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [jsu_pkg::BYTE_W-1:0] s_tdata,
  input  logic                      full,
  output logic                      push,
  output jsu_pkg::tok_t             tok
);
  import jsu_pkg::*;

  logic [BYTE_W-1:0] quote_char;
  logic [BYTE_W-1:0] c;

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_char <= QUOTE_RESET;
    end else if (cfg_wr_en) begin
      quote_char <= cfg_wr_data;
    end
  end

  assign s_tready = !full;
  assign push     = s_tvalid && s_tready;
  assign c        = s_tdata;

  always_comb begin
    tok           = '0;
    tok.raw       = c;
    tok.is_bslash = (c == CH_BSLASH);
    tok.is_quote  = (c == quote_char);
    tok.is_u      = (c == CH_U);
    tok.esc_known = 1'b1;
    case (c)
      CH_BSLASH, CH_DQUOTE, CH_SLASH: tok.esc_byte = c;
      CH_B:    tok.esc_byte = CTL_BS;
      CH_F:    tok.esc_byte = CTL_FF;
      CH_N:    tok.esc_byte = CTL_LF;
      CH_R:    tok.esc_byte = CTL_CR;
      CH_T:    tok.esc_byte = CTL_HT;
      default: begin
        tok.esc_byte  = '0;
        tok.esc_known = 1'b0;
      end
    endcase
    // hex digit value, upper and lower case letters
    if (c >= CH_0 && c <= CH_9) begin
      tok.hex_ok  = 1'b1;
      tok.hex_val = HEX_W'(c - CH_0);
    end else if (c >= CH_UA && c <= CH_UF) begin
      tok.hex_ok  = 1'b1;
      tok.hex_val = HEX_W'(c - CH_UA + 8'd10);
    end else if (c >= CH_LA && c <= CH_LF) begin
      tok.hex_ok  = 1'b1;
      tok.hex_val = HEX_W'(c - CH_LA + 8'd10);
    end else begin
      tok.hex_ok  = 1'b0;
      tok.hex_val = '0;
    end
  end

endmodule

// ----- src/jsu_back.sv -----
// ----------------------------------------------------------------------------
// jsu_back
// Escape state machine and registered result output.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      empty,
  input  jsu_pkg::tok_t             rd_tok,
  output logic                      pop,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [jsu_pkg::BYTE_W-1:0] m_tdata,
  output logic [jsu_pkg::KIND_W-1:0] m_tuser
);
  import jsu_pkg::*;
  `include "json_string_unescape_macros.svh"

  mode_t               mode;
  mode_t               mode_next;
  logic [1:0]          hex_count;
  logic [1:0]          hex_count_next;
  logic [HEXACC_W-1:0] hex_value;
  logic [HEXACC_W-1:0] hex_value_next;

  logic                res_valid;
  logic [BYTE_W-1:0]   res_byte;
  logic [KIND_W-1:0]   res_kind;

  assign pop = !empty && (!m_tvalid || m_tready);

  // next state
  always_comb begin
    mode_next      = MODE_TEXT;
    hex_count_next = '0;
    hex_value_next = '0;
    case (mode)
      MODE_ESC: begin
        if (rd_tok.is_u) begin
          mode_next = MODE_HEX;
        end
      end
      MODE_HEX: begin
        if (rd_tok.hex_ok && hex_count != HEX_LAST) begin
          mode_next      = MODE_HEX;
          hex_count_next = hex_count + 1'b1;
          hex_value_next = {hex_value[HEXACC_W-HEX_W-1:0], rd_tok.hex_val};
        end
      end
      default: begin
        if (rd_tok.is_bslash) begin
          mode_next = MODE_ESC;
        end
      end
    endcase
  end

  // result
  always_comb begin
    res_valid = 1'b0;
    res_byte  = '0;
    res_kind  = KIND_BYTE;
    case (mode)
      MODE_ESC: begin
        if (!rd_tok.is_u && rd_tok.esc_known) begin
          res_valid = 1'b1;
          res_byte  = rd_tok.esc_byte;
        end
      end
      MODE_HEX: begin
        if (!rd_tok.hex_ok) begin
          res_valid = 1'b1;
          res_kind  = KIND_BAD_HEX;
        end else if (hex_count == HEX_LAST) begin
          res_valid = 1'b1;
          // code fits a byte only when the first two digits were zero
          if (hex_value[HEXACC_W-1:HEX_W] != '0) begin
            res_kind = KIND_TOO_BIG;
          end else begin
            res_byte = {hex_value[HEX_W-1:0], rd_tok.hex_val};
          end
        end
      end
      default: begin
        if (!rd_tok.is_bslash) begin
          res_valid = 1'b1;
          if (rd_tok.is_quote) begin
            res_kind = KIND_END;
          end else begin
            res_byte = rd_tok.raw;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_TEXT;
      hex_count <= '0;
      hex_value <= '0;
    end else if (pop) begin
      mode      <= mode_next;
      hex_count <= hex_count_next;
      hex_value <= hex_value_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop && res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      m_tdata <= res_byte;
      m_tuser <= res_kind;
    end
  end

  `JSU_ASSERT_NOW(a_text_no_count, mode == MODE_TEXT, hex_count == '0, "digit count outside hex")
  `JSU_ASSERT_NOW(a_text_no_acc, mode == MODE_TEXT, hex_value == '0, "stale hex accumulator")
  `JSU_ASSERT_NOW(a_zero_data, m_tvalid && m_tuser != KIND_BYTE, m_tdata == '0,
    "nonzero byte on end or error beat")
  `JSU_ASSERT_NEXT(a_esc_one_byte, pop && mode == MODE_ESC, mode != MODE_ESC,
    "escape mode held past one byte")

endmodule

// ----- src/json_string_unescape.sv -----
// an accepted byte is written into the token queue, then decoded into the output register
// throughput: one byte per cycle while the output is not stalled
// a four-entry token queue lets the input side run ahead while the output stalls
// reset: synchronous active-high rst clears the queue, the escape state and
// the output valid, and sets the terminator byte to double quote
// ----------------------------------------------------------------------------
// json_string_unescape
// Decodes the escaped body of a JSON string into raw bytes, one byte, end or error per beat.
// ----------------------------------------------------------------------------
module json_string_unescape (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [jsu_pkg::BYTE_W-1:0] cfg_wr_data,   // quote_char
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [jsu_pkg::BYTE_W-1:0] s_axis_tdata,  // [7:0] byte_in
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [jsu_pkg::BYTE_W-1:0] m_axis_tdata,  // [7:0] byte_out
  output logic [jsu_pkg::KIND_W-1:0] m_axis_tuser   // [1:0] kind
);
  import jsu_pkg::*;

  tok_t wr_tok;
  tok_t rd_tok;
  logic push;
  logic pop;
  logic full;
  logic empty;

  jsu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_axis_tvalid),
    .s_tready    (s_axis_tready),
    .s_tdata     (s_axis_tdata),
    .full        (full),
    .push        (push),
    .tok         (wr_tok)
  );

  jsu_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_tok (wr_tok),
    .full   (full),
    .pop    (pop),
    .rd_tok (rd_tok),
    .empty  (empty)
  );

  jsu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .rd_tok   (rd_tok),
    .pop      (pop),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata),
    .m_tuser  (m_axis_tuser)
  );

endmodule
